// ===== src/erk_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the echo reply tracker.
// No dependencies; every other file of the block imports this package.
package erk_pkg;

	// Default sizing of the top level
	localparam int DUP_SLOTS_DEF      = 1024;
	localparam int MIN_ICMP_BYTES_DEF = 8;

	// Stream and configuration port widths
	localparam int IN_DATA_W  = 168;
	localparam int OUT_DATA_W = 240;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// Register reset values
	localparam logic [15:0] PAYLOAD_LEN_RST = 16'd56;

	// Timing arithmetic
	localparam logic [15:0] TIMING_MIN_PAYLOAD = 16'd16;
	localparam logic signed [21:0] USEC_PER_SEC = 22'sd1000000;
	localparam logic signed [47:0] TICKS_PER_SEC = 48'sd10000;
	// floor(x / 100) == (x * USEC_RECIP) >> USEC_RECIP_SHIFT for x below 2^21
	localparam logic [21:0] USEC_RECIP = 22'd2684355;
	localparam int USEC_RECIP_SHIFT = 28;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PAYLOAD_LEN = 2'd0,
		CFG_SESSION_ID  = 2'd1,
		CFG_QUIET       = 2'd2,
		CFG_VERBOSE     = 2'd3
	} cfg_idx_t;

	// Result status codes
	typedef enum logic [2:0] {
		ST_NEW     = 3'd0,
		ST_DUP     = 3'd1,
		ST_FOREIGN = 3'd2,
		ST_SHORT   = 3'd3,
		ST_OTHER   = 3'd4,
		ST_SENT    = 3'd5
	} status_t;

	// One input transaction, unpacked
	typedef struct packed {
		logic        req_type;
		logic [15:0] packet_len;
		logic [7:0]  icmp_kind;
		logic [15:0] reply_id;
		logic [15:0] reply_seq;
		logic [31:0] sent_sec;
		logic [19:0] sent_usec;
		logic [31:0] recv_sec;
		logic [19:0] recv_usec;
		logic [7:0]  hop_ttl;
	} in_item_t;

	// Classified item handed from the front end to the statistics stage
	typedef struct packed {
		status_t            status;   // ST_NEW stands for any matching reply
		logic               do_time;
		logic               ttl_ok;
		logic [7:0]         ttl;
		logic signed [47:0] sec_ticks;
		logic signed [14:0] usec_ticks;
	} prep_t;

	// One result transaction, unpacked
	typedef struct packed {
		status_t     status;
		logic [15:0] sent_seq;
		logic [31:0] trip_time;
		logic [31:0] received_count;
		logic [31:0] repeat_count;
		logic [31:0] min_trip;
		logic [31:0] max_trip;
		logic [47:0] trip_sum;
		logic        ttl_valid;
		logic [7:0]  ttl_value;
	} result_t;

endpackage

// ===== src/erk_front.sv =====
`timescale 1ns / 1ps
// Front end: input register (s1) and classification / slot / trip-part stage (s2).
// Depends on erk_pkg.
module erk_front #(
	parameter int DUP_SLOTS      = erk_pkg::DUP_SLOTS_DEF,
	parameter int MIN_ICMP_BYTES = erk_pkg::MIN_ICMP_BYTES_DEF
) (
	input  logic                          clk,
	input  logic                          load_s1,
	input  logic                          load_s2,
	input  erk_pkg::in_item_t             item,
	input  logic [15:0]                   payload_length,
	input  logic [15:0]                   session_id,
	input  logic                          quiet_mode,
	input  logic                          verbose_mode,
	output logic [$clog2(DUP_SLOTS)-1:0]  rd_slot,
	output logic [$clog2(DUP_SLOTS)-1:0]  slot_s2,
	output erk_pkg::prep_t                prep_s2
);
	import erk_pkg::*;

	localparam int SLOT_W = $clog2(DUP_SLOTS);
	// floor(2^32 / DUP_SLOTS); the quotient estimate is at most one low
	localparam logic [32:0] SLOT_RECIP = 33'((64'd1 << 32) / DUP_SLOTS);
	localparam logic [16:0] SLOTS_17   = 17'(DUP_SLOTS);

	in_item_t           item_s1;
	logic [15:0]        q_est_s1;
	logic signed [20:0] usec_adj_s1;
	logic signed [33:0] sec_adj_s1;

	logic [48:0]        q_prod;
	logic signed [21:0] usec_diff;
	logic               borrow;
	logic signed [21:0] usec_adj;
	logic signed [33:0] sec_diff;

	logic [31:0]        q_times_n;
	logic [16:0]        rem;
	logic [16:0]        rem_sub;

	logic signed [47:0] sec_ext;
	logic               usec_neg;
	logic [20:0]        usec_mag;
	logic [42:0]        usec_prod;
	logic signed [14:0] usec_q;

	logic [16:0]        min_len;
	prep_t              prep;

	// Estimate slot quotient and borrow-adjust timestamps on the way in
	assign q_prod    = 49'(item.reply_seq) * 49'(SLOT_RECIP);
	assign usec_diff = $signed({2'b00, item.recv_usec}) - $signed({2'b00, item.sent_usec});
	assign borrow    = usec_diff[21];
	assign usec_adj  = borrow ? usec_diff + USEC_PER_SEC : usec_diff;
	assign sec_diff  = $signed({2'b00, item.recv_sec}) - $signed({2'b00, item.sent_sec})
		- $signed({33'd0, borrow});

	// Input register
	always_ff @(posedge clk) begin
		if (load_s1) begin
			item_s1     <= item;
			q_est_s1    <= q_prod[47:32];
			usec_adj_s1 <= usec_adj[20:0];
			sec_adj_s1  <= sec_diff;
		end
	end

	// Finish seq modulo slot count with one correction step
	assign q_times_n = 32'(q_est_s1) * 32'(DUP_SLOTS);
	assign rem       = {1'b0, item_s1.reply_seq} - q_times_n[16:0];
	assign rem_sub   = rem - SLOTS_17;
	assign rd_slot   = (rem >= SLOTS_17) ? rem_sub[SLOT_W-1:0] : rem[SLOT_W-1:0];

	// Scale seconds and microseconds to 100 us ticks
	assign sec_ext   = 48'(sec_adj_s1);
	assign usec_neg  = usec_adj_s1[20];
	assign usec_mag  = usec_neg ? 21'(-usec_adj_s1) : 21'(usec_adj_s1);
	assign usec_prod = 43'(usec_mag) * 43'(USEC_RECIP);
	assign usec_q    = $signed({1'b0, usec_prod[USEC_RECIP_SHIFT+13:USEC_RECIP_SHIFT]});

	// Classify: transmit records first, then length, then type, then identifier
	assign min_len = {1'b0, payload_length} + 17'(MIN_ICMP_BYTES);

	always_comb begin
		prep            = '0;
		prep.ttl        = item_s1.hop_ttl;
		prep.sec_ticks  = sec_ext * TICKS_PER_SEC;
		prep.usec_ticks = usec_neg ? -usec_q : usec_q;
		if (!item_s1.req_type) begin
			prep.status = ST_SENT;
		end else if ({1'b0, item_s1.packet_len} < min_len) begin
			prep.status = ST_SHORT;
		end else if (item_s1.icmp_kind != 8'd0) begin
			prep.status = ST_OTHER;
			prep.ttl_ok = verbose_mode;
		end else if (item_s1.reply_id != session_id) begin
			prep.status = ST_FOREIGN;
		end else begin
			prep.status  = ST_NEW;
			prep.do_time = payload_length >= TIMING_MIN_PAYLOAD;
			prep.ttl_ok  = !quiet_mode;
		end
	end

	// Stage register
	always_ff @(posedge clk) begin
		if (load_s2) begin
			prep_s2 <= prep;
			slot_s2 <= rd_slot;
		end
	end

endmodule

// ===== src/erk_bitmap.sv =====
`timescale 1ns / 1ps
// Reply-seen bitmap: one-bit memory with a clearing pass after reset and
// a one-entry write bypass for back-to-back accesses. Depends on erk_pkg.
module erk_bitmap #(
	parameter int DUP_SLOTS = erk_pkg::DUP_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(DUP_SLOTS)-1:0]  rd_addr,
	input  logic [$clog2(DUP_SLOTS)-1:0]  chk_addr,
	input  logic                          wr_en,
	input  logic [$clog2(DUP_SLOTS)-1:0]  wr_addr,
	input  logic                          wr_data,
	output logic                          seen,
	output logic                          busy
);
	import erk_pkg::*;

	localparam int SLOT_W = $clog2(DUP_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DUP_SLOTS - 1);

	logic              mem [DUP_SLOTS];
	logic              rd_q;
	logic [SLOT_W-1:0] clr_cnt_q;
	logic              busy_q;
	logic              byp_valid_q;
	logic [SLOT_W-1:0] byp_addr_q;
	logic              byp_data_q;

	logic              m_we;
	logic [SLOT_W-1:0] m_addr;
	logic              m_data;

	// Clearing pass owns the write port until every slot is zero
	assign m_we   = busy_q || wr_en;
	assign m_addr = busy_q ? clr_cnt_q : wr_addr;
	assign m_data = busy_q ? 1'b0 : wr_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b1;
			clr_cnt_q <= '0;
		end else if (busy_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == LAST_SLOT) begin
				busy_q <= 1'b0;
			end
		end
	end

	// Memory array
	always_ff @(posedge clk) begin
		if (m_we) begin
			mem[m_addr] <= m_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Remember the last write for a read issued on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_valid_q <= 1'b0;
		end else if (m_we) begin
			byp_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (m_we) begin
			byp_addr_q <= m_addr;
			byp_data_q <= m_data;
		end
	end

	assign seen = (byp_valid_q && byp_addr_q == chk_addr) ? byp_data_q : rd_q;
	assign busy = busy_q;

endmodule

// ===== src/erk_stats.sv =====
`timescale 1ns / 1ps
// Statistics stage: trip clamp, counters, min/max/sum and the result register.
// Depends on erk_pkg.
module erk_stats #(
	parameter int DUP_SLOTS = erk_pkg::DUP_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv_s2,
	input  logic                          out_ready,
	input  erk_pkg::prep_t                prep_s2,
	input  logic [$clog2(DUP_SLOTS)-1:0]  slot_s2,
	input  logic                          seen_s2,
	output logic                          wr_en,
	output logic [$clog2(DUP_SLOTS)-1:0]  wr_addr,
	output logic                          wr_data,
	output logic                          out_valid,
	output erk_pkg::result_t              result
);
	import erk_pkg::*;

	localparam int SLOT_W = $clog2(DUP_SLOTS);
	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DUP_SLOTS - 1);

	logic [15:0]       seq_q;
	logic [SLOT_W-1:0] tx_slot_q;
	logic [31:0]       uniq_q;
	logic [31:0]       dup_q;
	logic [31:0]       min_q;
	logic [31:0]       max_q;
	logic [47:0]       sum_q;
	logic              out_valid_q;
	status_t           status_q;
	logic [15:0]       sent_seq_q;
	logic [31:0]       trip_q;
	logic              ttl_valid_q;
	logic [7:0]        ttl_value_q;

	logic signed [48:0] trip_raw;
	logic [31:0]        trip;
	logic               is_sent;
	logic               is_match;
	status_t            status;

	// Combine ticks and clamp to 32 bits
	assign trip_raw = 49'(prep_s2.sec_ticks) + 49'(prep_s2.usec_ticks);
	assign trip     = trip_raw[48] ? 32'd0 : (|trip_raw[47:32]) ? '1 : trip_raw[31:0];

	assign is_sent  = prep_s2.status == ST_SENT;
	assign is_match = prep_s2.status == ST_NEW;
	assign status   = (is_match && seen_s2) ? ST_DUP : prep_s2.status;

	// Bitmap write: clear on transmit, set on matching reply
	assign wr_en   = adv_s2 && (is_sent || is_match);
	assign wr_addr = is_sent ? tx_slot_q : slot_s2;
	assign wr_data = is_match;

	// Update running state when the stage advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= '0;
			tx_slot_q <= '0;
			uniq_q    <= '0;
			dup_q     <= '0;
			min_q     <= '1;
			max_q     <= '0;
			sum_q     <= '0;
		end else if (adv_s2) begin
			if (is_sent) begin
				seq_q     <= seq_q + 1'b1;
				tx_slot_q <= (seq_q == 16'hFFFF || tx_slot_q == LAST_SLOT) ? '0 :
					tx_slot_q + 1'b1;
			end
			if (is_match) begin
				if (seen_s2) begin
					dup_q <= dup_q + 1'b1;
				end else begin
					uniq_q <= uniq_q + 1'b1;
				end
			end
			if (prep_s2.do_time) begin
				sum_q <= sum_q + {16'd0, trip};
				if (trip < min_q) begin
					min_q <= trip;
				end
				if (trip > max_q) begin
					max_q <= trip;
				end
			end
		end
	end

	// Result register handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s2) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			status_q    <= status;
			sent_seq_q  <= is_sent ? seq_q : 16'd0;
			trip_q      <= prep_s2.do_time ? trip : 32'd0;
			ttl_valid_q <= prep_s2.ttl_ok;
			ttl_value_q <= prep_s2.ttl_ok ? prep_s2.ttl : 8'd0;
		end
	end

	// Counters are only touched when the result register loads
	always_comb begin
		result.status         = status_q;
		result.sent_seq       = sent_seq_q;
		result.trip_time      = trip_q;
		result.received_count = uniq_q;
		result.repeat_count   = dup_q;
		result.min_trip       = min_q;
		result.max_trip       = max_q;
		result.trip_sum       = sum_q;
		result.ttl_valid      = ttl_valid_q;
		result.ttl_value      = ttl_value_q;
	end

	assign out_valid = out_valid_q;

endmodule

// ===== src/echo_reply_tracker.sv =====
`timescale 1ns / 1ps
// Top level of the echo reply tracker: stream ports, configuration registers
// and stage control. Depends on erk_pkg, erk_front, erk_bitmap, erk_stats.

// Takes one transaction per clock cycle while not stalled by m_tready or the
// bitmap clearing, and returns exactly one result per transaction, in order.
// A result passes the input register, the classify/bitmap-read stage and the
// result register; the single-port read of the reply-seen bitmap in the
// middle stage, with a one-entry bypass for the write made on the same edge,
// is what lets consecutive replies to one sequence slot follow each other
// every cycle. After reset the bitmap is cleared one slot per cycle, and
// s_tready stays low till it ends; configuration writes are taken meanwhile.
// Write configuration only while no transaction is in flight.
module echo_reply_tracker #(
	parameter int DUP_SLOTS      = erk_pkg::DUP_SLOTS_DEF,
	parameter int MIN_ICMP_BYTES = erk_pkg::MIN_ICMP_BYTES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// s_tdata from bit 0: packet_len, icmp_kind, reply_id, reply_seq, sent_sec,
	// sent_usec, recv_sec, recv_usec, hop_ttl
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [erk_pkg::IN_DATA_W-1:0]   s_tdata,
	input  logic                            s_tuser,   // req_type
	// m_tdata from bit 0: sent_seq, trip_time, received_count, repeat_count,
	// min_trip, max_trip, trip_sum, ttl_valid, ttl_value, zero fill
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [erk_pkg::OUT_DATA_W-1:0]  m_tdata,
	output logic [2:0]                      m_tuser,   // status
	input  logic                            cfg_we,
	input  logic [erk_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [erk_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import erk_pkg::*;

	localparam int SLOT_W = $clog2(DUP_SLOTS);

	logic [15:0]       payload_length_q;
	logic [15:0]       session_id_q;
	logic              quiet_q;
	logic              verbose_q;

	logic              s1_valid_q;
	logic              s2_valid_q;
	logic              out_load;
	logic              adv_s1;
	logic              adv_s2;
	logic              accept;
	logic              clr_busy;

	in_item_t          item;
	prep_t             prep_s2;
	logic [SLOT_W-1:0] rd_slot;
	logic [SLOT_W-1:0] slot_s2;
	logic              seen_s2;
	logic              wr_en;
	logic [SLOT_W-1:0] wr_addr;
	logic              wr_data;
	logic              out_valid;
	result_t           result;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			payload_length_q <= PAYLOAD_LEN_RST;
			session_id_q     <= '0;
			quiet_q          <= 1'b0;
			verbose_q        <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_PAYLOAD_LEN: payload_length_q <= cfg_data;
				CFG_SESSION_ID:  session_id_q     <= cfg_data;
				CFG_QUIET:       quiet_q          <= cfg_data[0];
				CFG_VERBOSE:     verbose_q        <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Stage control: each stage moves when the one after it has room
	assign out_load = !out_valid || m_tready;
	assign adv_s2   = s2_valid_q && out_load;
	assign adv_s1   = s1_valid_q && (!s2_valid_q || adv_s2);
	assign s_tready = (!s1_valid_q || adv_s1) && !clr_busy;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			s2_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv_s1) begin
				s1_valid_q <= 1'b0;
			end
			if (adv_s1) begin
				s2_valid_q <= 1'b1;
			end else if (adv_s2) begin
				s2_valid_q <= 1'b0;
			end
		end
	end

	// Unpack the input transaction
	always_comb begin
		item.req_type   = s_tuser;
		item.packet_len = s_tdata[15:0];
		item.icmp_kind  = s_tdata[23:16];
		item.reply_id   = s_tdata[39:24];
		item.reply_seq  = s_tdata[55:40];
		item.sent_sec   = s_tdata[87:56];
		item.sent_usec  = s_tdata[107:88];
		item.recv_sec   = s_tdata[139:108];
		item.recv_usec  = s_tdata[159:140];
		item.hop_ttl    = s_tdata[167:160];
	end

	erk_front #(
		.DUP_SLOTS      (DUP_SLOTS),
		.MIN_ICMP_BYTES (MIN_ICMP_BYTES)
	) u_front (
		.clk            (clk),
		.load_s1        (accept),
		.load_s2        (adv_s1),
		.item           (item),
		.payload_length (payload_length_q),
		.session_id     (session_id_q),
		.quiet_mode     (quiet_q),
		.verbose_mode   (verbose_q),
		.rd_slot        (rd_slot),
		.slot_s2        (slot_s2),
		.prep_s2        (prep_s2)
	);

	erk_bitmap #(
		.DUP_SLOTS (DUP_SLOTS)
	) u_bitmap (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (adv_s1),
		.rd_addr  (rd_slot),
		.chk_addr (slot_s2),
		.wr_en    (wr_en),
		.wr_addr  (wr_addr),
		.wr_data  (wr_data),
		.seen     (seen_s2),
		.busy     (clr_busy)
	);

	erk_stats #(
		.DUP_SLOTS (DUP_SLOTS)
	) u_stats (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv_s2    (adv_s2),
		.out_ready (m_tready),
		.prep_s2   (prep_s2),
		.slot_s2   (slot_s2),
		.seen_s2   (seen_s2),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.wr_data   (wr_data),
		.out_valid (out_valid),
		.result    (result)
	);

	// Pack the result transaction
	assign m_tvalid = out_valid;
	assign m_tuser  = result.status;
	assign m_tdata  = {7'd0, result.ttl_value, result.ttl_valid, result.trip_sum,
		result.max_trip, result.min_trip, result.repeat_count,
		result.received_count, result.trip_time, result.sent_seq};

endmodule

// ===== src/erk_check.sv =====
`timescale 1ns / 1ps
// Port-level checker for the echo reply tracker, bound to the top level.
// Depends on erk_pkg and echo_reply_tracker.
module erk_check (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [erk_pkg::OUT_DATA_W-1:0]  m_tdata,
	input logic [2:0]                      m_tuser
);
	import erk_pkg::*;

	logic [15:0] sent_seq;
	logic [31:0] trip_time;
	logic [31:0] min_trip;
	logic [31:0] max_trip;
	logic        ttl_valid;
	logic [7:0]  ttl_value;

	assign sent_seq  = m_tdata[15:0];
	assign trip_time = m_tdata[47:16];
	assign min_trip  = m_tdata[143:112];
	assign max_trip  = m_tdata[175:144];
	assign ttl_valid = m_tdata[224];
	assign ttl_value = m_tdata[232:225];

	// Hold a stalled result transaction
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	// No TTL report for sent, short or foreign items
	a_no_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_SENT || m_tuser == ST_SHORT || m_tuser == ST_FOREIGN)
		|-> !ttl_valid)
		else $error("TTL reported for an item that carries none");

	// Unreported TTL reads as zero
	a_ttl_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !ttl_valid |-> ttl_value == 8'd0)
		else $error("ttl_value nonzero without ttl_valid");

	// Only transmit results carry a sequence; only matching replies carry a trip time
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == ST_SENT || sent_seq == 16'd0) &&
		(m_tuser == ST_NEW || m_tuser == ST_DUP || trip_time == 32'd0))
		else $error("field set for the wrong result kind");

	// A timed reply lies within the running minimum and maximum
	a_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == ST_NEW || m_tuser == ST_DUP) && trip_time != 32'd0
		|-> min_trip <= trip_time && max_trip >= trip_time)
		else $error("trip time outside min/max");

endmodule

bind echo_reply_tracker erk_check u_erk_check (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
